FILE: rtl/sjt_pkg.sv
// Shared types, constants and the UTF-8 encoder for the Shift-JIS transcoder.
`default_nettype none

package sjt_pkg;

    localparam int SJT_TABLE_DEPTH = 1024;

    localparam logic [15:0] REPLACEMENT_CHAR = 16'hFFFD;
    localparam logic [15:0] KANA_BASE        = 16'hFF61;
    localparam logic [7:0]  KANA_FIRST       = 8'hA1;
    localparam logic [7:0]  KANA_LAST        = 8'hDF;
    localparam logic [7:0]  LEAD1_FIRST      = 8'h81;
    localparam logic [7:0]  LEAD1_LAST       = 8'h9F;
    localparam logic [7:0]  LEAD2_FIRST      = 8'hE0;
    localparam logic [7:0]  LEAD2_LAST       = 8'hFC;
    localparam logic [12:0] CAP_LIMIT        = 13'd4096;
    localparam logic [12:0] CHAR_HEADROOM    = 13'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_TABLE_ENTRIES = 2'd0;
    localparam logic [1:0] CFG_OUT_CAPACITY  = 2'd1;

    // request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_BYTE = 1'b1;

    typedef struct packed {
        logic        start;
        logic [15:0] key;
    } srch_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] ch;
    } srch_rsp_t;

    typedef struct packed {
        logic [1:0] len;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } enc_t;

    function automatic enc_t utf8_enc(input logic [15:0] u);
        enc_t e;
        e = '0;
        if (u < 16'h0080) begin
            e.len = 2'd1;
            e.b0  = u[7:0];
        end else if (u < 16'h0800) begin
            e.len = 2'd2;
            e.b0  = 8'hC0 | {3'b000, u[10:6]};
            e.b1  = 8'h80 | {2'b00, u[5:0]};
        end else begin
            e.len = 2'd3;
            e.b0  = 8'hE0 | {4'b0000, u[15:12]};
            e.b1  = 8'h80 | {2'b00, u[11:6]};
            e.b2  = 8'h80 | {2'b00, u[5:0]};
        end
        return e;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/shift_jis_to_utf8_transcoder.sv
// Top level of the Shift-JIS to UTF-8 transcoder: decode, table, emit.
//
// Requests arrive one Shift-JIS byte (or one table load) at a time and leave as UTF-8
// bytes, with a zero terminator flagged tlast that carries the string's byte count.
// A table load writes one entry. An ASCII, half-width katakana or stray byte is encoded
// and sent as its UTF-8 bytes (1 to 3). A two-byte character runs a binary search over
// the loaded table: each probe is one read of the table memory's registered read port
// followed by a compare, and the found character is then sent as its UTF-8 bytes. A NUL
// adds the terminator. The table is not cleared after reset; only loaded entries may be
// searched. The output register lets the next request enter while the last byte of the
// previous one still waits.
`default_nettype none

module shift_jis_to_utf8_transcoder import sjt_pkg::*; #(
    parameter int TABLE_DEPTH = SJT_TABLE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] in_byte, [17:8] entry_index, [33:18] entry_code, [49:34] entry_char,
    // [55:50] zero
    input  wire logic [55:0] s_tdata,
    // [0] req_type
    input  wire logic        s_tuser,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] out_byte, [19:8] byte_count, [23:20] zero
    output logic [23:0]      m_tdata,
    output logic             m_tlast    // is_last
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        T_IDLE   = 3'b001,
        T_SEARCH = 3'b010,
        T_EMIT   = 3'b100
    } top_state_t;

    top_state_t state_reg, state_next;

    logic [10:0] entries_reg, entries_next;
    logic [12:0] capacity_reg, capacity_next;
    logic [7:0]  held_lead_reg, held_lead_next;
    logic        lead_pending_reg, lead_pending_next;
    logic [11:0] written_reg, written_next;
    logic        full_reg, full_next;
    logic        m_valid_reg, m_valid_next;

    logic [7:0]  buf_reg [4];
    logic [7:0]  buf_next [4];
    logic [1:0]  idx_reg, idx_next;
    logic [2:0]  total_reg, total_next;
    logic        term_reg, term_next;
    logic [11:0] term_cnt_reg, term_cnt_next;
    logic [23:0] m_data_reg, m_data_next;
    logic        m_last_reg, m_last_next;

    logic        s_accept;
    logic        req_type;
    logic [7:0]  in_byte;
    logic [9:0]  entry_index;
    logic [15:0] entry_code;
    logic [15:0] entry_char;

    logic [31:0]   idx_ext;
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;
    logic [31:0]   te_ext;
    logic [NW-1:0] n_entries;

    srch_req_t srch_req;
    srch_rsp_t srch_rsp;

    logic [12:0] cap_cl;
    logic        fits;
    logic        out_free;
    logic        load_buf;
    logic        enc_on;
    logic        term;
    logic [15:0] u_sel;
    enc_t        enc;
    logic [1:0]  len;
    logic [11:0] wb_sum;
    logic        emit_last;

    assign req_type    = s_tuser;
    assign in_byte     = s_tdata[7:0];
    assign entry_index = s_tdata[17:8];
    assign entry_code  = s_tdata[33:18];
    assign entry_char  = s_tdata[49:34];

    assign s_tready  = (state_reg == T_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // loads beyond the table depth are dropped
    assign idx_ext = 32'(entry_index);
    assign ram_we  = s_accept && (req_type == REQ_LOAD) && (idx_ext < 32'(TABLE_DEPTH));

    assign te_ext    = 32'(entries_reg);
    assign n_entries = (te_ext > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(entries_reg);

    sjt_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_ext[AW-1:0]),
        .wdata ({entry_code, entry_char}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sjt_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (srch_req),
        .n_entries (n_entries),
        .rd_addr   (ram_raddr),
        .rd_data   (ram_rdata),
        .rsp       (srch_rsp)
    );

    assign cap_cl   = (capacity_reg > CAP_LIMIT) ? CAP_LIMIT : capacity_reg;
    assign fits     = ({1'b0, written_reg} + CHAR_HEADROOM) < cap_cl;
    assign out_free = !m_valid_reg || m_tready;

    assign enc       = utf8_enc(u_sel);
    assign len       = enc_on ? enc.len : 2'd0;
    assign wb_sum    = written_reg + {10'd0, len};
    assign emit_last = ({1'b0, idx_reg} == (total_reg - 3'd1));

    always_comb begin
        entries_next  = entries_reg;
        capacity_next = capacity_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_TABLE_ENTRIES: entries_next  = cfg_data[10:0];
                CFG_OUT_CAPACITY:  capacity_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next        = state_reg;
        held_lead_next    = held_lead_reg;
        lead_pending_next = lead_pending_reg;
        full_next         = full_reg;
        srch_req.start    = 1'b0;
        srch_req.key      = {held_lead_reg, in_byte};
        load_buf          = 1'b0;
        enc_on            = 1'b0;
        term              = 1'b0;
        u_sel             = REPLACEMENT_CHAR;
        unique case (state_reg)
            T_IDLE: begin
                if (s_accept && (req_type == REQ_BYTE)) begin
                    if (lead_pending_reg) begin
                        lead_pending_next = 1'b0;
                        held_lead_next    = '0;
                        if (in_byte == 8'h00) begin
                            // lead cut short by NUL
                            enc_on   = 1'b1;
                            term     = 1'b1;
                            load_buf = 1'b1;
                        end else begin
                            srch_req.start = 1'b1;
                            state_next     = T_SEARCH;
                        end
                    end else if (in_byte == 8'h00) begin
                        term     = 1'b1;
                        load_buf = 1'b1;
                    end else if (full_reg || !fits) begin
                        full_next = 1'b1;
                    end else if (in_byte < 8'h80) begin
                        u_sel    = {8'h00, in_byte};
                        enc_on   = 1'b1;
                        load_buf = 1'b1;
                    end else if (in_byte >= KANA_FIRST && in_byte <= KANA_LAST) begin
                        u_sel    = KANA_BASE + {8'h00, in_byte - KANA_FIRST};
                        enc_on   = 1'b1;
                        load_buf = 1'b1;
                    end else if ((in_byte >= LEAD1_FIRST && in_byte <= LEAD1_LAST) ||
                                 (in_byte >= LEAD2_FIRST && in_byte <= LEAD2_LAST)) begin
                        held_lead_next    = in_byte;
                        lead_pending_next = 1'b1;
                    end else begin
                        enc_on   = 1'b1;
                        load_buf = 1'b1;
                    end
                end
            end
            T_SEARCH: begin
                if (srch_rsp.done) begin
                    u_sel    = srch_rsp.ch;
                    enc_on   = 1'b1;
                    load_buf = 1'b1;
                end
            end
            T_EMIT: begin
                if (out_free && emit_last) begin
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
        if (load_buf) begin
            state_next = T_EMIT;
            if (term) begin
                full_next = 1'b0;
            end
        end
    end

    always_comb begin
        written_next  = written_reg;
        buf_next      = buf_reg;
        idx_next      = idx_reg;
        total_next    = total_reg;
        term_next     = term_reg;
        term_cnt_next = term_cnt_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        if (load_buf) begin
            written_next  = term ? 12'd0 : wb_sum;
            term_cnt_next = wb_sum;
            term_next     = term;
            idx_next      = '0;
            total_next    = {1'b0, len} + {2'b00, term};
            buf_next[0]   = enc.b0;
            buf_next[1]   = enc.b1;
            buf_next[2]   = enc.b2;
            buf_next[3]   = 8'h00;
            if (term) begin
                buf_next[len] = 8'h00;
            end
        end
        if (state_reg == T_EMIT && out_free) begin
            m_valid_next = 1'b1;
            m_last_next  = term_reg && emit_last;
            m_data_next  = {4'h0, (term_reg && emit_last) ? term_cnt_reg : 12'd0,
                            buf_reg[idx_reg]};
            idx_next     = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= T_IDLE;
            entries_reg      <= '0;
            capacity_reg     <= 13'd1024;
            held_lead_reg    <= '0;
            lead_pending_reg <= 1'b0;
            written_reg      <= '0;
            full_reg         <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            entries_reg      <= entries_next;
            capacity_reg     <= capacity_next;
            held_lead_reg    <= held_lead_next;
            lead_pending_reg <= lead_pending_next;
            written_reg      <= written_next;
            full_reg         <= full_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg      <= buf_next;
        idx_reg      <= idx_next;
        total_reg    <= total_next;
        term_reg     <= term_next;
        term_cnt_reg <= term_cnt_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

endmodule

`default_nettype wire

FILE: rtl/sjt_table_ram.sv
// Code table memory: one write port, one registered read port.
`default_nettype none

module sjt_table_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [31:0]        rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/sjt_search.sv
// Binary search sequencer over the code table; each probe is a read (S_PROBE) then a compare (S_CHECK).
`default_nettype none

module sjt_search import sjt_pkg::*; #(
    parameter  int TABLE_DEPTH = SJT_TABLE_DEPTH,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int NW = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire srch_req_t     req,
    input  wire logic [NW-1:0] n_entries,
    output logic [AW-1:0]      rd_addr,
    input  wire logic [31:0]   rd_data,
    output srch_rsp_t          rsp
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_PROBE = 3'b010,
        S_CHECK = 3'b100
    } srch_state_t;

    srch_state_t state_reg, state_next;

    // search window is [lo, hix)
    logic [NW-1:0] lo_reg, lo_next;
    logic [NW-1:0] hix_reg, hix_next;
    logic [NW-1:0] mid_reg, mid_next;
    logic [15:0]   code_reg, code_next;

    logic [NW:0]   mid_sum;
    logic [NW-1:0] mid_w;
    logic [15:0]   probe_key;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hix_reg} - {{NW{1'b0}}, 1'b1};
    assign mid_w     = mid_sum[NW:1];
    assign rd_addr   = mid_w[AW-1:0];
    assign probe_key = rd_data[31:16];

    always_comb begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hix_next   = hix_reg;
        mid_next   = mid_reg;
        code_next  = code_reg;
        rsp        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (req.start) begin
                    lo_next    = '0;
                    hix_next   = n_entries;
                    code_next  = req.key;
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                if (lo_reg < hix_reg) begin
                    mid_next   = mid_w;
                    state_next = S_CHECK;
                end else begin
                    rsp.done   = 1'b1;
                    rsp.ch     = REPLACEMENT_CHAR;
                    state_next = S_IDLE;
                end
            end
            S_CHECK: begin
                if (probe_key == code_reg) begin
                    rsp.done   = 1'b1;
                    rsp.ch     = rd_data[15:0];
                    state_next = S_IDLE;
                end else begin
                    if (probe_key < code_reg) begin
                        lo_next = mid_reg + {{(NW-1){1'b0}}, 1'b1};
                    end else begin
                        hix_next = mid_reg;
                    end
                    state_next = S_PROBE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg   <= lo_next;
        hix_reg  <= hix_next;
        mid_reg  <= mid_next;
        code_reg <= code_next;
    end

endmodule

`default_nettype wire

FILE: rtl/sjt_checker.sv
// Port-level checks for the transcoder, bound to the top level.
`default_nettype none

module sjt_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // count field is zero on every byte but the terminator
    a_count_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[19:8] == 12'd0)
        else $error("byte count on a non-terminator result");

    // terminator byte is NUL
    a_term_is_nul: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[7:0] == 8'h00)
        else $error("terminator byte is not zero");

    // nothing left pending across reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind shift_jis_to_utf8_transcoder sjt_checker u_sjt_checker (.*);

`default_nettype wire

FILE: dv/shift_jis_to_utf8_transcoder_chk.sv
// Checker for the Shift-JIS to UTF-8 transcoder: predicts the UTF-8 stream and compares it.
module shift_jis_to_utf8_transcoder_chk import sjt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tlast,
    output logic [31:0] mismatches,
    output logic [31:0] outstanding
);

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [11:0] count;
    } utf8_byte_t;

    utf8_byte_t  utf8_expected[$];
    logic [31:0] code_map [0:SJT_TABLE_DEPTH-1];
    logic [7:0]  lead_byte;
    logic        lead_held;
    logic [11:0] bytes_out;
    logic        buf_full;
    logic [10:0] entries_reg;
    logic [12:0] capacity_reg;

    // binary search over the loaded prefix of the code table
    function automatic logic [15:0] table_lookup(input logic [15:0] key);
        int lo, hi, mid, n;
        logic [15:0] found;
        logic hit;
        n = int'(entries_reg);
        if (n > SJT_TABLE_DEPTH) n = SJT_TABLE_DEPTH;
        lo = 0;
        hi = n - 1;
        found = REPLACEMENT_CHAR;
        hit = 1'b0;
        while (!hit && lo <= hi) begin
            mid = (lo + hi) / 2;
            if (code_map[mid][31:16] == key) begin
                found = code_map[mid][15:0];
                hit = 1'b1;
            end else if (code_map[mid][31:16] < key) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return found;
    endfunction

    task automatic queue_byte(input logic [7:0] d, input logic last, input logic [11:0] cnt);
        utf8_byte_t e;
        e.data = d;
        e.last = last;
        e.count = cnt;
        utf8_expected.push_back(e);
    endtask

    task automatic emit_char(input logic [15:0] u);
        if (u < 16'h0080) begin
            queue_byte(u[7:0], 1'b0, 12'd0);
            bytes_out = bytes_out + 12'd1;
        end else if (u < 16'h0800) begin
            queue_byte({3'b110, u[10:6]}, 1'b0, 12'd0);
            queue_byte({2'b10, u[5:0]}, 1'b0, 12'd0);
            bytes_out = bytes_out + 12'd2;
        end else begin
            queue_byte({4'b1110, u[15:12]}, 1'b0, 12'd0);
            queue_byte({2'b10, u[11:6]}, 1'b0, 12'd0);
            queue_byte({2'b10, u[5:0]}, 1'b0, 12'd0);
            bytes_out = bytes_out + 12'd3;
        end
    endtask

    task automatic close_string();
        queue_byte(8'h00, 1'b1, bytes_out);
        bytes_out = 12'd0;
        buf_full = 1'b0;
        lead_held = 1'b0;
        lead_byte = 8'h00;
    endtask

    task automatic transcode_request(input logic kind, input logic [7:0] b,
                                     input logic [9:0] idx, input logic [15:0] code,
                                     input logic [15:0] ch);
        int cap;
        cap = int'(capacity_reg);
        if (cap > int'(CAP_LIMIT)) cap = int'(CAP_LIMIT);
        if (kind == REQ_LOAD) begin
            code_map[idx] = {code, ch};
        end else if (lead_held) begin
            // trail byte bypasses the capacity gate; NUL here closes with a replacement
            lead_held = 1'b0;
            if (b == 8'h00) emit_char(REPLACEMENT_CHAR);
            else emit_char(table_lookup({lead_byte, b}));
            lead_byte = 8'h00;
            if (b == 8'h00) close_string();
        end else if (b == 8'h00) begin
            close_string();
        end else if (buf_full || !(int'(bytes_out) + int'(CHAR_HEADROOM) < cap)) begin
            buf_full = 1'b1;
        end else if (b < 8'h80) begin
            emit_char({8'h00, b});
        end else if (b >= KANA_FIRST && b <= KANA_LAST) begin
            emit_char(KANA_BASE + {8'h00, b - KANA_FIRST});
        end else if ((b >= LEAD1_FIRST && b <= LEAD1_LAST) ||
                     (b >= LEAD2_FIRST && b <= LEAD2_LAST)) begin
            lead_byte = b;
            lead_held = 1'b1;
        end else begin
            emit_char(REPLACEMENT_CHAR);
        end
    endtask

    always @(posedge aclk) begin : monitor
        utf8_byte_t got, want;
        if (!aresetn) begin
            utf8_expected.delete();
            lead_byte = 8'h00;
            lead_held = 1'b0;
            bytes_out = 12'd0;
            buf_full = 1'b0;
            entries_reg = 11'd0;
            capacity_reg = 13'd1024;
            mismatches = 0;
        end else begin
            // results leave a register, so compare before adding this edge's request
            if (m_tvalid && m_tready) begin
                got.data = m_tdata[7:0];
                got.last = m_tlast;
                got.count = m_tdata[19:8];
                if (utf8_expected.size() == 0) begin
                    $error("unexpected result: out_byte %h is_last %b byte_count %0d",
                           got.data, got.last, got.count);
                    mismatches = mismatches + 1;
                end else begin
                    want = utf8_expected.pop_front();
                    if (got.data !== want.data) begin
                        $error("out_byte expected %h, got %h", want.data, got.data);
                        mismatches = mismatches + 1;
                    end
                    if (got.last !== want.last) begin
                        $error("is_last expected %b, got %b", want.last, got.last);
                        mismatches = mismatches + 1;
                    end
                    if (got.count !== want.count) begin
                        $error("byte_count expected %0d, got %0d", want.count, got.count);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TABLE_ENTRIES: entries_reg = cfg_data[10:0];
                    CFG_OUT_CAPACITY:  capacity_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                transcode_request(s_tuser, s_tdata[7:0], s_tdata[17:8], s_tdata[33:18],
                                  s_tdata[49:34]);
        end
        outstanding = utf8_expected.size();
    end

endmodule

FILE: dv/shift_jis_to_utf8_transcoder_tb.sv
// Testbench top: drives Shift-JIS requests and settings into the transcoder, gives the verdict.
module shift_jis_to_utf8_transcoder_tb;
    import sjt_pkg::*;

    localparam int IDLE_PCT       = 7;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_UNITS    = 25;
    localparam int MAIN_UNITS     = 60;
    localparam int TABLE_FILL     = 32;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [31:0] mismatches;
    logic [31:0] outstanding;

    logic        calm;
    int          stall_asks;
    int          cur_entries;
    logic [15:0] tbl_code [0:SJT_TABLE_DEPTH-1];

    shift_jis_to_utf8_transcoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    shift_jis_to_utf8_transcoder_chk chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: random backpressure, plus one long hold-off per stall_asks bump
    initial begin
        int stalls_done;
        stalls_done = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_asks != stalls_done) begin
                stalls_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic logic [15:0] rand_char();
        logic [15:0] u;
        case ($urandom_range(0, 2))
            0:       u = 16'($urandom_range(0, 16'h007F));
            1:       u = 16'($urandom_range(16'h0080, 16'h07FF));
            default: u = 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
        return u;
    endfunction

    function automatic logic [7:0] rand_lead();
        logic [7:0] b;
        if ($urandom_range(0, 1)) b = 8'($urandom_range(LEAD1_FIRST, LEAD1_LAST));
        else b = 8'($urandom_range(LEAD2_FIRST, LEAD2_LAST));
        return b;
    endfunction

    function automatic logic [7:0] rand_stray();
        logic [7:0] b;
        case ($urandom_range(0, 4))
            0:       b = 8'h80;
            1:       b = 8'hA0;
            default: b = 8'($urandom_range(8'hFD, 8'hFF));
        endcase
        return b;
    endfunction

    // one request; leaves s_tvalid high at the following negedge for the caller to reuse
    task automatic push(input logic kind, input logic [7:0] b, input logic [9:0] idx,
                        input logic [15:0] code, input logic [15:0] ch);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, ch, code, idx, b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        logic [9:0]  idx;
        logic [15:0] code, ch;
        idx = 10'($urandom_range(0, 1023));
        code = 16'($urandom_range(0, 16'hFFFF));
        ch = 16'($urandom_range(0, 16'hFFFF));
        push(REQ_BYTE, b, idx, code, ch);
    endtask

    task automatic send_code(input logic [15:0] c);
        send_byte(c[15:8]);
        send_byte(c[7:0]);
    endtask

    task automatic load_entry(input logic [9:0] idx, input logic [15:0] code,
                              input logic [15:0] ch);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        push(REQ_LOAD, b, idx, code, ch);
        tbl_code[idx] = code;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // stop offering, wait out all results and the search pipeline
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic send_unit();
        int          roll;
        int          pick;
        logic [7:0]  b;
        logic [9:0]  idx;
        logic [15:0] code, ch;
        roll = $urandom_range(0, 99);
        b = 8'($urandom_range(1, 255));
        if (roll < 38) begin
            b = 8'($urandom_range(1, 127));
            send_byte(b);
        end else if (roll < 52) begin
            b = 8'($urandom_range(KANA_FIRST, KANA_LAST));
            send_byte(b);
        end else if (roll < 70) begin
            if (cur_entries > 0) begin
                pick = $urandom_range(0, cur_entries - 1);
                send_code(tbl_code[pick]);
            end else begin
                send_code({rand_lead(), b});
            end
        end else if (roll < 80) begin
            send_code({rand_lead(), b});
        end else if (roll < 85) begin
            send_byte(rand_stray());
        end else if (roll < 93) begin
            send_byte(8'h00);
        end else if (roll < 95) begin
            send_byte(rand_lead());
            send_byte(8'h00);
        end else if (roll < 97) begin
            idx = 10'($urandom_range(0, 1023));
            code = 16'($urandom_range(0, 16'hFFFF));
            ch = 16'($urandom_range(0, 16'hFFFF));
            load_entry(idx, code, ch);
        end else begin
            b = 8'($urandom_range(0, 255));
            send_byte(b);
        end
    endtask

    initial begin
        int          i, p;
        logic [15:0] key;
        logic [12:0] n_set, cap_set;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = REQ_LOAD;
        calm = 1'b0;
        stall_asks = 0;
        cur_entries = 0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty table, default capacity: every byte class once
        load_entry(10'd1023, 16'hFFFF, 16'hFFFF);
        load_entry(10'd1022, 16'h0000, 16'h0000);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h7F);
        send_byte(KANA_FIRST);
        send_byte(KANA_LAST);
        send_byte(8'h80);
        send_byte(8'hA0);
        send_byte(8'hFF);
        send_code({LEAD1_FIRST, 8'h40});
        send_byte(LEAD2_LAST);
        send_byte(8'h00);

        // zero capacity, then a gate that trips after two bytes
        settle();
        write_reg(CFG_OUT_CAPACITY, 13'd0);
        send_byte(8'h41);
        send_byte(8'h00);
        settle();
        write_reg(CFG_OUT_CAPACITY, 13'd6);
        send_byte(8'h41);
        send_byte(8'h42);
        send_byte(8'h43);
        send_byte(8'h44);
        send_byte(8'h00);

        // sorted table prefix; searches never go past it
        key = 16'h8140;
        for (i = 0; i < TABLE_FILL; i++) begin
            load_entry(i[9:0], key, rand_char());
            key = key + 16'($urandom_range(1, 3));
        end
        settle();
        write_reg(CFG_TABLE_ENTRIES, 13'(TABLE_FILL));
        write_reg(CFG_OUT_CAPACITY, 13'd4096);
        cur_entries = TABLE_FILL;
        send_code(tbl_code[0]);
        send_code(tbl_code[TABLE_FILL-1]);
        send_byte(8'h00);
        for (i = 0; i < MAIN_UNITS; i++) begin
            if (i == 12) stall_asks++;
            calm = (i >= 30 && i < 50);
            send_unit();
        end
        calm = 1'b0;
        send_byte(8'h00);

        for (p = 0; p < 4; p++) begin
            settle();
            case ($urandom_range(0, 4))
                0:       n_set = 13'd1;
                1:       n_set = 13'd2;
                2:       n_set = 13'd7;
                3:       n_set = 13'd20;
                default: n_set = 13'(TABLE_FILL);
            endcase
            case ($urandom_range(0, 6))
                0:       cap_set = 13'd5;
                1:       cap_set = 13'd6;
                2:       cap_set = 13'd7;
                3:       cap_set = 13'd12;
                4:       cap_set = 13'd30;
                5:       cap_set = 13'd200;
                default: cap_set = 13'd4095;
            endcase
            write_reg(CFG_TABLE_ENTRIES, n_set);
            write_reg(CFG_OUT_CAPACITY, cap_set);
            cur_entries = int'(n_set);
            for (i = 0; i < PHASE_UNITS; i++) send_unit();
            send_byte(8'h00);
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/sjt_pkg.sv
rtl/sjt_table_ram.sv
rtl/sjt_search.sv
rtl/shift_jis_to_utf8_transcoder.sv
rtl/sjt_checker.sv
dv/shift_jis_to_utf8_transcoder_chk.sv
dv/shift_jis_to_utf8_transcoder_tb.sv
